@@ sv/sjb_pkg.sv @@
// Shared types and constants for the sequence jitter buffer.
package sjb_pkg;

    localparam int SLOTS = 8;
    localparam int IDX_W = $clog2(SLOTS);
    localparam int SEQ_W = 16;
    localparam int TAG_W = 16;
    localparam int TIME_W = 32;
    localparam int CAP_W = 3;
    localparam int DEAD_W = 8;
    localparam int CFG_DATA_W = 8;

    localparam logic [SEQ_W-1:0] HALF_RANGE = 16'h8000;
    localparam logic [SEQ_W-1:0] SLOTS_SEQ = SEQ_W'(SLOTS);
    localparam logic [CAP_W-1:0] CAP_RESET = 3'd6;
    localparam logic [DEAD_W-1:0] DEAD_RESET = 8'd4;

    typedef enum logic
    {
        REG_CAPACITY = 1'b0,
        REG_DEAD_SECONDS = 1'b1
    } reg_index_t;

    typedef enum logic
    {
        MODE_INSERT = 1'b0,
        MODE_REMOVE = 1'b1
    } mode_t;

    typedef enum logic [2:0]
    {
        ST_INSERTED = 3'd0,
        ST_RESYNC = 3'd1,
        ST_OLD = 3'd2,
        ST_DUP = 3'd3,
        ST_NOTHING = 3'd4,
        ST_GOOD = 3'd5,
        ST_LOST = 3'd6
    } status_t;

    typedef enum logic
    {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    typedef struct packed
    {
        mode_t mode;
        logic [SEQ_W-1:0] seq;
        logic [TAG_W-1:0] payload_tag;
        logic [TIME_W-1:0] now_seconds;
    } req_t;

    typedef struct packed
    {
        status_t status;
        logic [TAG_W-1:0] tag_out;
        logic [SEQ_W-1:0] seq_out;
    } rsp_t;

    typedef struct packed
    {
        logic en;
        logic [IDX_W-1:0] addr;
        logic [TAG_W-1:0] data;
    } ram_wr_t;

endpackage

@@ sv/sequence_jitter_buffer_core.sv @@
// Top level of the sequence jitter buffer: sequencing, tag store and result register.
//
// Reorder buffer for sequence-numbered packets.
// req channel (valid/ready): one word per operation. mode selects insert
// (seq, payload_tag, now_seconds) or remove of the next packet in order.
// rsp channel (valid/ready): exactly one word per request: status,
// tag_out and seq_out.
// cfg port: cfg_wr_en with cfg_index 0 writes capacity, 1 writes
// dead_seconds; change only while no request is in flight.
// A request is registered on acceptance, together with its tag store read; the
// decide and commit step follows in the execute state and writes the result register.
// Requests do not overlap: the store read is followed by the read-modify-write
// of the window, and req_ready drops while a request is in flight.
// When rsp_ready is low the result word holds; a following request waits in
// the decide stage until the result register frees, then commits.
// Reset: all slots empty, window bottom and top zero, last insert time zero,
// capacity 6, dead_seconds 4. No clearing pass is needed.
module sequence_jitter_buffer_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  sjb_pkg::reg_index_t            cfg_index,
    input  logic [sjb_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  sjb_pkg::req_t                  req,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output sjb_pkg::rsp_t                  rsp
);

    sjb_pkg::state_t state_reg, state_next;
    sjb_pkg::req_t item_reg;
    sjb_pkg::rsp_t rsp_reg;
    sjb_pkg::rsp_t rsp_next;
    sjb_pkg::ram_wr_t ram_wr;
    logic rsp_valid_reg, rsp_valid_next;
    logic accept;
    logic commit;
    logic [sjb_pkg::IDX_W-1:0] rd_addr;
    logic [sjb_pkg::TAG_W-1:0] rd_tag;

    assign req_ready = (state_reg == sjb_pkg::S_IDLE);
    assign accept = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp = rsp_reg;

    always_comb
    begin
        state_next = state_reg;
        commit = 1'b0;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        unique case (state_reg)
            sjb_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = sjb_pkg::S_EXEC;
                end
            end
            sjb_pkg::S_EXEC:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    commit = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next = sjb_pkg::S_IDLE;
                end
            end
            default:
                state_next = sjb_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sjb_pkg::S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= req;
        end
        if (commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    sjb_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .item      (item_reg),
        .commit    (commit),
        .rd_tag    (rd_tag),
        .rd_addr   (rd_addr),
        .ram_wr    (ram_wr),
        .rsp_next  (rsp_next)
    );

    sjb_tag_ram #(
        .DEPTH (sjb_pkg::SLOTS),
        .WIDTH (sjb_pkg::TAG_W)
    ) u_tag_ram (
        .clk     (clk),
        .wr_en   (ram_wr.en && commit),
        .wr_addr (ram_wr.addr),
        .wr_data (ram_wr.data),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_tag)
    );

endmodule

@@ sv/sjb_tag_ram.sv @@
// Slot tag store: one write port, one registered read port.
module sjb_tag_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ sv/sjb_window.sv @@
// Window pointers, slot occupancy, config registers and insert/remove decision.
module sjb_window (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  sjb_pkg::reg_index_t               cfg_index,
    input  logic [sjb_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  sjb_pkg::req_t                     req,
    input  sjb_pkg::req_t                     item,
    input  logic                              commit,
    input  logic [sjb_pkg::TAG_W-1:0]         rd_tag,
    output logic [sjb_pkg::IDX_W-1:0]         rd_addr,
    output sjb_pkg::ram_wr_t                  ram_wr,
    output sjb_pkg::rsp_t                     rsp_next
);

    logic [sjb_pkg::CAP_W-1:0]  capacity_reg;
    logic [sjb_pkg::DEAD_W-1:0] dead_reg;
    logic [sjb_pkg::SLOTS-1:0]  full_reg, full_next;
    logic [sjb_pkg::SEQ_W-1:0]  bottom_reg, bottom_next;
    logic [sjb_pkg::SEQ_W-1:0]  top_reg, top_next;
    logic [sjb_pkg::TIME_W-1:0] last_time_reg, last_time_next;

    logic [sjb_pkg::IDX_W-1:0]  ins_idx;
    logic [sjb_pkg::IDX_W-1:0]  head_idx;
    logic [sjb_pkg::SEQ_W-1:0]  ahead;
    logic [sjb_pkg::SEQ_W-1:0]  depth;
    logic [sjb_pkg::SEQ_W-1:0]  cap_ext;
    logic                       live;

    assign ins_idx = item.seq[sjb_pkg::IDX_W-1:0];
    assign head_idx = bottom_reg[sjb_pkg::IDX_W-1:0];
    assign ahead = item.seq - bottom_reg;
    assign depth = top_reg - bottom_reg;
    assign cap_ext = sjb_pkg::SEQ_W'(capacity_reg);
    assign live = ({1'b0, last_time_reg} + (sjb_pkg::TIME_W + 1)'(dead_reg))
                  > {1'b0, item.now_seconds};

    // tag read for a remove targets the head slot
    assign rd_addr = (req.mode == sjb_pkg::MODE_INSERT) ? req.seq[sjb_pkg::IDX_W-1:0]
                                                        : head_idx;

    always_comb
    begin
        full_next = full_reg;
        bottom_next = bottom_reg;
        top_next = top_reg;
        last_time_next = last_time_reg;
        ram_wr.en = 1'b0;
        ram_wr.addr = ins_idx;
        ram_wr.data = item.payload_tag;
        rsp_next.status = sjb_pkg::ST_NOTHING;
        rsp_next.tag_out = '0;
        rsp_next.seq_out = '0;
        if (item.mode == sjb_pkg::MODE_INSERT)
        begin
            rsp_next.seq_out = item.seq;
            priority if (live && (ahead > sjb_pkg::HALF_RANGE))
            begin
                rsp_next.status = sjb_pkg::ST_OLD;
            end
            else if (ahead > sjb_pkg::SLOTS_SEQ)
            begin
                full_next = '0;
                full_next[ins_idx] = 1'b1;
                bottom_next = item.seq - cap_ext;
                top_next = item.seq + 16'd1;
                last_time_next = item.now_seconds;
                ram_wr.en = 1'b1;
                rsp_next.status = sjb_pkg::ST_RESYNC;
            end
            else if (full_reg[ins_idx])
            begin
                rsp_next.status = sjb_pkg::ST_DUP;
            end
            else
            begin
                full_next[ins_idx] = 1'b1;
                if (ahead >= depth)
                begin
                    top_next = item.seq + 16'd1;
                end
                last_time_next = item.now_seconds;
                ram_wr.en = 1'b1;
                rsp_next.status = sjb_pkg::ST_INSERTED;
            end
        end
        else
        begin
            priority if (depth == '0)
            begin
                rsp_next.status = sjb_pkg::ST_NOTHING;
            end
            else if (full_reg[head_idx])
            begin
                full_next[head_idx] = 1'b0;
                bottom_next = bottom_reg + 16'd1;
                rsp_next.status = sjb_pkg::ST_GOOD;
                rsp_next.tag_out = rd_tag;
                rsp_next.seq_out = bottom_reg;
            end
            else if (depth > cap_ext)
            begin
                bottom_next = bottom_reg + 16'd1;
                rsp_next.status = sjb_pkg::ST_LOST;
                rsp_next.seq_out = bottom_reg;
            end
            else
            begin
                rsp_next.status = sjb_pkg::ST_NOTHING;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= sjb_pkg::CAP_RESET;
            dead_reg <= sjb_pkg::DEAD_RESET;
            full_reg <= '0;
            bottom_reg <= '0;
            top_reg <= '0;
            last_time_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    sjb_pkg::REG_CAPACITY:
                        capacity_reg <= cfg_data[sjb_pkg::CAP_W-1:0];
                    sjb_pkg::REG_DEAD_SECONDS:
                        dead_reg <= cfg_data[sjb_pkg::DEAD_W-1:0];
                    default:
                        ;
                endcase
            end
            if (commit)
            begin
                full_reg <= full_next;
                bottom_reg <= bottom_next;
                top_reg <= top_next;
                last_time_reg <= last_time_next;
            end
        end
    end

endmodule
